[hw/rtl/etga_pkg.sv]
// Shared types and constants for the extent table gap allocator.
// No dependencies.
package etga_pkg;
	localparam int ENTRIES  = 16;
	localparam int IDX_BITS = 4;
	localparam int POS_BITS = 48;
	localparam int LEN_BITS = 31;

	typedef logic [2:0] opcode_t;
	localparam opcode_t OP_WRITE = 3'd0;
	localparam opcode_t OP_CLEAR = 3'd1;
	localparam opcode_t OP_FIND  = 3'd2;
	localparam opcode_t OP_STATS = 3'd3;
	localparam opcode_t OP_USED  = 3'd4;

	typedef logic [2:0] status_t;
	localparam status_t ST_DONE    = 3'd0;
	localparam status_t ST_LARGE   = 3'd1;
	localparam status_t ST_NOSPACE = 3'd2;
	localparam status_t ST_OVERLAP = 3'd3;
	localparam status_t ST_NOUSED  = 3'd4;

	localparam logic [POS_BITS-1:0] POS_ONES = '1;
endpackage

[hw/rtl/etga_sort.sv]
// Rank table and its insertion sort: one compare-and-shift step a cycle.
// Depends on etga_pkg.
module etga_sort (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [etga_pkg::POS_BITS-1:0] starts [etga_pkg::ENTRIES],
	input  logic [etga_pkg::IDX_BITS-1:0] rd_rank,
	output logic [etga_pkg::IDX_BITS-1:0] rd_entry,
	output logic busy
);
	import etga_pkg::*;

	logic [IDX_BITS-1:0] order_q [ENTRIES];
	logic [IDX_BITS:0] i_q;
	logic [IDX_BITS-1:0] j_q;
	logic [IDX_BITS-1:0] held_q;
	logic busy_q;

	assign rd_entry = order_q[rd_rank];
	assign busy = busy_q;

	// one step: compare the entry above the hole with the held key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ENTRIES; k++) order_q[k] <= IDX_BITS'(k);
			busy_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			held_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q <= (IDX_BITS+1)'(1);
			j_q <= IDX_BITS'(1);
			held_q <= order_q[1];
		end else if (busy_q) begin
			if (j_q != '0 && starts[order_q[j_q - 1'b1]] > starts[held_q]) begin
				order_q[j_q] <= order_q[j_q - 1'b1];
				j_q <= j_q - 1'b1;
			end else begin
				order_q[j_q] <= held_q;
				if (i_q == (IDX_BITS+1)'(ENTRIES - 1)) begin
					busy_q <= 1'b0;
				end else begin
					i_q <= i_q + 1'b1;
					j_q <= i_q[IDX_BITS-1:0] + 1'b1;
					held_q <= order_q[i_q[IDX_BITS-1:0] + 1'b1];
				end
			end
		end
	end
endmodule

[hw/rtl/extent_table_gap_allocator.sv]
// Top level of the extent table gap allocator: table, walk sequencer, output.
// Depends on etga_pkg and etga_sort.
//
// Usage: one request channel (opcode, entry_index, entry_position,
// request_length) and one result channel (status, result_position,
// gap_count, gap_total), both valid/ready. Every request yields exactly
// one result transfer.
// Timing: one request at a time. A find, statistics or used-length request
// walks the sixteen ranks, one rank a cycle through a single shared
// subtract/compare unit, then closes the walk and settles the status before
// out_valid rises; an early stop shortens the walk. A write or clear runs
// the insertion sort of the rank table, one compare-and-shift step a cycle,
// and its length depends on how far entries move. An unknown opcode answers
// in the cycle after its transfer.
// in_ready is high only while idle; the result is held in an output
// register until taken, and a stalled receiver simply holds the block.
// Reset: all entries empty (start all ones, length zero), ranks identity,
// no result pending.
module extent_table_gap_allocator (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] opcode,
	input  logic [3:0] entry_index,
	input  logic [47:0] entry_position,
	input  logic [30:0] request_length,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] status,
	output logic [47:0] result_position,
	output logic [4:0] gap_count,
	output logic [47:0] gap_total
);
	import etga_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_SORT, S_WALK, S_DONE, S_OUT} state_t;
	state_t state_q;

	logic [POS_BITS-1:0] start_q [ENTRIES];
	logic [LEN_BITS-1:0] len_q [ENTRIES];
	opcode_t op_q;
	logic [LEN_BITS-1:0] req_q;
	logic [IDX_BITS:0] rank_q;
	logic [POS_BITS:0] left_q;
	logic found_q, ovl_q, large_q, stop_q;
	logic [POS_BITS-1:0] lpos_q, lsize_q, rpos_q, total_q;
	logic [4:0] count_q;
	status_t st_q;

	logic sort_start, sort_busy;
	logic [IDX_BITS-1:0] rd_rank, ent;

	etga_sort u_sort (
		.clk, .arst_n, .start(sort_start), .starts(start_q),
		.rd_rank, .rd_entry(ent), .busy(sort_busy)
	);

	// shared unit: gap from previous end to this start
	logic [POS_BITS-1:0] right;
	logic [POS_BITS:0] gap, endp;
	logic [LEN_BITS:0] twice;
	assign rd_rank = (op_q == OP_USED) ? ~rank_q[IDX_BITS-1:0] : rank_q[IDX_BITS-1:0];
	assign right = start_q[ent];
	assign gap = {1'b0, right} - left_q;
	assign endp = {1'b0, right} + (POS_BITS+1)'(len_q[ent]);
	assign twice = {req_q, 1'b0};
	assign sort_start = (state_q == S_IDLE) && in_valid && (opcode == OP_WRITE ||
		opcode == OP_CLEAR);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int k = 0; k < ENTRIES; k++) begin
				start_q[k] <= POS_ONES;
				len_q[k] <= '0;
			end
			op_q <= OP_WRITE;
			req_q <= '0;
			rank_q <= '0;
			left_q <= '0;
			{found_q, ovl_q, large_q, stop_q} <= '0;
			{lpos_q, lsize_q, rpos_q, total_q, count_q} <= '0;
			st_q <= ST_DONE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					op_q <= opcode;
					req_q <= request_length;
					rank_q <= '0;
					left_q <= '0;
					{found_q, ovl_q, large_q, stop_q} <= '0;
					{lpos_q, lsize_q, rpos_q, total_q, count_q} <= '0;
					st_q <= ST_DONE;
					if (opcode == OP_WRITE || opcode == OP_CLEAR) begin
						start_q[entry_index] <= (opcode == OP_WRITE) ? entry_position : POS_ONES;
						len_q[entry_index] <= (opcode == OP_WRITE) ? request_length : '0;
						state_q <= S_SORT;
					end else if (opcode == OP_FIND || opcode == OP_STATS || opcode == OP_USED)
						state_q <= S_WALK;
					else
						state_q <= S_OUT;
				end
				S_SORT: if (!sort_start && !sort_busy) state_q <= S_OUT;
				S_WALK: begin
					if (rank_q == (IDX_BITS+1)'(ENTRIES) || stop_q) begin
						state_q <= S_DONE;
					end else begin
						rank_q <= rank_q + 1'b1;
						unique case (op_q)
							OP_FIND: begin
								if (gap[POS_BITS]) begin
									ovl_q <= 1'b1; stop_q <= 1'b1;
								end else if (gap == (POS_BITS+1)'(req_q)) begin
									found_q <= 1'b1; stop_q <= 1'b1;
									rpos_q <= left_q[POS_BITS-1:0];
								end else if (gap > (POS_BITS+1)'(twice) &&
										(!large_q || {1'b0, lsize_q} > gap)) begin
									large_q <= 1'b1;
									lpos_q <= left_q[POS_BITS-1:0];
									lsize_q <= gap[POS_BITS-1:0];
								end
								left_q <= endp;
							end
							OP_STATS: begin
								if (right == POS_ONES) stop_q <= 1'b1;
								else if (gap[POS_BITS]) begin
									st_q <= ST_OVERLAP; stop_q <= 1'b1;
								end else begin
									if (gap != '0) begin
										count_q <= count_q + 1'b1;
										total_q <= total_q + gap[POS_BITS-1:0];
									end
									left_q <= endp;
								end
							end
							default: begin
								if (len_q[ent] != '0) begin
									stop_q <= 1'b1;
									found_q <= 1'b1;
									rpos_q <= endp[POS_BITS] ? POS_ONES : endp[POS_BITS-1:0];
								end
							end
						endcase
					end
				end
				S_DONE: begin
					state_q <= S_OUT;
					if (op_q == OP_FIND) begin
						if (found_q) st_q <= ST_DONE;
						else if (ovl_q) begin st_q <= ST_OVERLAP; rpos_q <= '0; end
						else if (large_q) begin st_q <= ST_LARGE; rpos_q <= lpos_q; end
						else begin st_q <= ST_NOSPACE; rpos_q <= '0; end
					end else if (op_q == OP_USED)
						st_q <= found_q ? ST_DONE : ST_NOUSED;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign status = st_q;
	assign result_position = rpos_q;
	assign gap_count = count_q;
	assign gap_total = total_q;
endmodule

[hw/rtl/etga_checker.sv]
// Port-level checks for the extent table gap allocator, bound to the top.
// Depends on extent_table_gap_allocator.
module etga_port_checks (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] status,
	input logic [4:0] gap_count
);
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("request taken with result pending");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped under stall");
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second request taken too early");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'd4 && gap_count <= 5'd16) else $error("bad result");
endmodule

bind extent_table_gap_allocator etga_port_checks u_etga_port_checks (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .status, .gap_count
);
